>>> design/qau_pkg.sv
`default_nettype none
package qau_pkg;

  localparam logic [1:0] CMD_MUL  = 2'd0;
  localparam logic [1:0] CMD_CONJ = 2'd1;
  localparam logic [1:0] CMD_NORM = 2'd2;

  localparam int SUM_W  = 65;  // sum of four squares, up to 2^64
  localparam int ROOT_W = 33;  // floor of its root, up to 2^32
  localparam int QUO_W  = 33;  // quotient bits kept below the overflow check

  typedef struct packed {
    logic [1:0]       cmd;
    logic [3:0][31:0] r;     // multiply or conjugate result
    logic             sat;
    logic             degen;
    logic [3:0]       neg;   // sign of each component of a
    logic [3:0][31:0] mag;   // magnitude of each component of a
  } carry_t;

endpackage
`default_nettype wire

>>> design/qau_front.sv
`default_nettype none
module qau_front import qau_pkg::*; #(
  parameter int FRAC_BITS = 24
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      up_ready,
  input  wire logic [1:0]           cmd_in,
  input  wire logic [3:0][31:0]     a_in,
  input  wire logic [3:0][31:0]     b_in,
  output logic                      out_valid,
  input  wire logic                 dn_ready,
  output carry_t                    c_out,
  output logic [SUM_W-1:0]          s_out
);

  localparam int PW = 66;

  logic                   va;
  logic [1:0]             cmd_a;
  logic [3:0][31:0]       a_a;
  logic [3:0][31:0]       m_a;
  logic signed [63:0]     pm [4][4];
  logic [63:0]            sq [4];

  logic                   vb;
  logic                   ready_a;
  logic                   ready_b;

  logic [3:0][31:0]       m_next;
  logic signed [63:0]     pm_next [4][4];
  logic [63:0]            sq_next [4];

  logic [3:0][31:0]       rm;
  logic [3:0]             sm;
  logic [3:0][31:0]       rc;
  logic [3:0]             sc;
  carry_t                 c_next;
  logic [SUM_W-1:0]       s_next;

  function automatic logic signed [PW-1:0] ext(input logic signed [63:0] p);
    ext = PW'(p);
  endfunction

  function automatic logic [32:0] round_sat(input logic signed [PW-1:0] s);
    logic signed [PW-1:0] t;
    logic signed [PW-1:0] q;
    logic [32:0]          res;
    t = s + (PW'(1) <<< (FRAC_BITS - 1));
    q = t >>> FRAC_BITS;
    if (q > PW'(64'sd2147483647)) res = {1'b1, 32'h7fffffff};
    else if (q < -PW'(64'sd2147483648)) res = {1'b1, 32'h80000000};
    else res = {1'b0, q[31:0]};
    round_sat = res;
  endfunction

  assign ready_b  = !vb || dn_ready;
  assign ready_a  = !va || ready_b;
  assign up_ready = ready_a;
  assign out_valid = vb;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      m_next[i] = a_in[i][31] ? (32'd0 - a_in[i]) : a_in[i];
      sq_next[i] = {32'd0, m_next[i]} * {32'd0, m_next[i]};
      for (int j = 0; j < 4; j++) begin
        pm_next[i][j] = $signed(a_in[i]) * $signed(b_in[j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (ready_a) begin
      va <= in_valid;
    end
    if (ready_a && in_valid) begin
      cmd_a <= cmd_in;
      a_a   <= a_in;
      m_a   <= m_next;
      for (int i = 0; i < 4; i++) begin
        sq[i] <= sq_next[i];
        for (int j = 0; j < 4; j++) pm[i][j] <= pm_next[i][j];
      end
    end
  end

  always_comb begin
    logic [32:0] t0, t1, t2, t3;
    t0 = round_sat(ext(pm[0][0]) - ext(pm[1][1]) - ext(pm[2][2]) - ext(pm[3][3]));
    t1 = round_sat(ext(pm[0][1]) + ext(pm[1][0]) + ext(pm[2][3]) - ext(pm[3][2]));
    t2 = round_sat(ext(pm[0][2]) - ext(pm[1][3]) + ext(pm[2][0]) + ext(pm[3][1]));
    t3 = round_sat(ext(pm[0][3]) + ext(pm[1][2]) - ext(pm[2][1]) + ext(pm[3][0]));
    rm = {t3[31:0], t2[31:0], t1[31:0], t0[31:0]};
    sm = {t3[32], t2[32], t1[32], t0[32]};
    rc[0] = a_a[0];
    sc[0] = 1'b0;
    for (int i = 1; i < 4; i++) begin
      // negating the most negative value clips to the top
      sc[i] = (a_a[i] == 32'h80000000);
      rc[i] = sc[i] ? 32'h7fffffff : (32'd0 - a_a[i]);
    end
    c_next.cmd   = cmd_a;
    c_next.r     = (cmd_a == CMD_MUL) ? rm : rc;
    c_next.sat   = (cmd_a == CMD_MUL) ? (|sm) : (|sc);
    c_next.degen = 1'b0;
    c_next.neg   = {a_a[3][31], a_a[2][31], a_a[1][31], a_a[0][31]};
    c_next.mag   = m_a;
    s_next = SUM_W'(sq[0]) + SUM_W'(sq[1]) + SUM_W'(sq[2]) + SUM_W'(sq[3]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (ready_b) begin
      vb <= va;
    end
    if (ready_b && va) begin
      c_out <= c_next;
      s_out <= s_next;
    end
  end

endmodule
`default_nettype wire

>>> design/qau_sqrt_cell.sv
`default_nettype none
module qau_sqrt_cell import qau_pkg::*; #(
  parameter int K = 0
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      up_ready,
  input  wire carry_t               c_in,
  input  wire logic [SUM_W-1:0]     s_in,
  input  wire logic [ROOT_W-1:0]    root_in,
  output logic                      out_valid,
  input  wire logic                 dn_ready,
  output carry_t                    c_out,
  output logic [SUM_W-1:0]          s_out,
  output logic [ROOT_W-1:0]         root_out
);

  localparam int TW = ROOT_W + 34;

  logic              v;
  logic [TW-1:0]     trial;
  logic              take;

  // (root + 2^k)^2 - root^2
  assign trial = (TW'(root_in) << (K + 1)) + (TW'(1) << (2 * K));
  assign take  = TW'(s_in) >= trial;

  assign up_ready  = !v || dn_ready;
  assign out_valid = v;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (up_ready) begin
      v <= in_valid;
    end
    if (up_ready && in_valid) begin
      c_out    <= c_in;
      s_out    <= take ? (s_in - trial[SUM_W-1:0]) : s_in;
      root_out <= take ? (root_in | (ROOT_W'(1) << K)) : root_in;
    end
  end

endmodule
`default_nettype wire

>>> design/qau_div_cell.sv
`default_nettype none
module qau_div_cell import qau_pkg::*; #(
  parameter int NW = 57,
  parameter int K  = 0
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        up_ready,
  input  wire carry_t                 c_in,
  input  wire logic [ROOT_W-1:0]      len_in,
  input  wire logic [3:0][NW-1:0]     n_in,
  input  wire logic [3:0][QUO_W-1:0]  q_in,
  input  wire logic [3:0]             ovf_in,
  output logic                        out_valid,
  input  wire logic                   dn_ready,
  output carry_t                      c_out,
  output logic [ROOT_W-1:0]           len_out,
  output logic [3:0][NW-1:0]          n_out,
  output logic [3:0][QUO_W-1:0]       q_out,
  output logic [3:0]                  ovf_out
);

  localparam int CW = NW + ROOT_W + 1;

  logic                   v;
  logic [CW-1:0]          dsh;
  logic [3:0][NW-1:0]     n_next;
  logic [3:0][QUO_W-1:0]  q_next;

  assign dsh = CW'(len_in) << K;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (CW'(n_in[i]) >= dsh) begin
        n_next[i] = n_in[i] - dsh[NW-1:0];
        q_next[i] = q_in[i] | (QUO_W'(1) << K);
      end else begin
        n_next[i] = n_in[i];
        q_next[i] = q_in[i];
      end
    end
  end

  assign up_ready  = !v || dn_ready;
  assign out_valid = v;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (up_ready) begin
      v <= in_valid;
    end
    if (up_ready && in_valid) begin
      c_out   <= c_in;
      len_out <= len_in;
      n_out   <= n_next;
      q_out   <= q_next;
      ovf_out <= ovf_in;
    end
  end

endmodule
`default_nettype wire

>>> design/quaternion_arith_unit.sv
`default_nettype none
// Quaternion multiply, conjugate and normalise on Q8.24 words. One beat is
// accepted per cycle while in_stall is low; every beat gives one result via
// two front stages (products, then sums and rounding), 33 square
// root cells resolving one root bit each, one set-up stage, 33 divider cells
// resolving one quotient bit for all four lanes, and the output register.
// Every stage holds its beat while the next one is not ready, so bubbles close
// up under stall. min_length must only be written while the unit is empty.
module quaternion_arith_unit import qau_pkg::*; #(
  parameter int FRAC_BITS = 24
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [30:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  command,
  input  wire logic [31:0] a_w,
  input  wire logic [31:0] a_x,
  input  wire logic [31:0] a_y,
  input  wire logic [31:0] a_z,
  input  wire logic [31:0] b_w,
  input  wire logic [31:0] b_x,
  input  wire logic [31:0] b_y,
  input  wire logic [31:0] b_z,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      r_w,
  output logic [31:0]      r_x,
  output logic [31:0]      r_y,
  output logic [31:0]      r_z,
  output logic             degenerate,
  output logic             saturated
);

  localparam int NW = 33 + FRAC_BITS;
  localparam int CW = NW + ROOT_W + 1;
  localparam int NCELL = ROOT_W;

  logic [30:0] min_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_length <= 31'd17;
    end else if (cfg_we) begin
      min_length <= cfg_data;
    end
  end

  // front
  logic             f_ready;
  logic             f_valid;
  carry_t           f_c;
  logic [SUM_W-1:0] f_s;

  // square root chain
  logic                sq_valid [NCELL+1];
  logic                sq_ready [NCELL+1];
  carry_t              sq_c     [NCELL+1];
  logic [SUM_W-1:0]    sq_s     [NCELL+1];
  logic [ROOT_W-1:0]   sq_root  [NCELL+1];

  // set-up stage
  logic                  st_v;
  logic                  st_ready;
  carry_t                st_c;
  logic [ROOT_W-1:0]     st_len;
  logic [3:0][NW-1:0]    st_n;
  logic [3:0]            st_ovf;
  carry_t                st_c_next;
  logic [3:0][NW-1:0]    st_n_next;
  logic [3:0]            st_ovf_next;

  // divider chain
  logic                  dv_valid [QUO_W+1];
  logic                  dv_ready [QUO_W+1];
  carry_t                dv_c     [QUO_W+1];
  logic [ROOT_W-1:0]     dv_len   [QUO_W+1];
  logic [3:0][NW-1:0]    dv_n     [QUO_W+1];
  logic [3:0][QUO_W-1:0] dv_q     [QUO_W+1];
  logic [3:0]            dv_ovf   [QUO_W+1];

  // output
  logic                  o_ready;
  logic [3:0][31:0]      o_r_next;
  logic                  o_sat_next;
  logic                  o_deg_next;
  logic [3:0][31:0]      o_r;

  qau_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .up_ready  (f_ready),
    .cmd_in    (command),
    .a_in      ({a_z, a_y, a_x, a_w}),
    .b_in      ({b_z, b_y, b_x, b_w}),
    .out_valid (f_valid),
    .dn_ready  (sq_ready[0]),
    .c_out     (f_c),
    .s_out     (f_s)
  );

  assign in_stall = !f_ready;

  assign sq_valid[0] = f_valid;
  assign sq_c[0]     = f_c;
  assign sq_s[0]     = f_s;
  assign sq_root[0]  = '0;
  assign sq_ready[NCELL] = st_ready;

  for (genvar g = 0; g < NCELL; g++) begin : g_sqrt
    qau_sqrt_cell #(.K(NCELL - 1 - g)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (sq_valid[g]),
      .up_ready  (sq_ready[g]),
      .c_in      (sq_c[g]),
      .s_in      (sq_s[g]),
      .root_in   (sq_root[g]),
      .out_valid (sq_valid[g+1]),
      .dn_ready  (sq_ready[g+1]),
      .c_out     (sq_c[g+1]),
      .s_out     (sq_s[g+1]),
      .root_out  (sq_root[g+1])
    );
  end

  always_comb begin
    st_c_next = sq_c[NCELL];
    st_c_next.degen = (sq_c[NCELL].cmd == CMD_NORM) &&
                      (sq_root[NCELL] <= ROOT_W'(min_length));
    for (int i = 0; i < 4; i++) begin
      // numerator carries half the divisor for round to nearest
      st_n_next[i] = (NW'(sq_c[NCELL].mag[i]) << FRAC_BITS) +
                     NW'(sq_root[NCELL] >> 1);
      st_ovf_next[i] = CW'(st_n_next[i]) >= (CW'(sq_root[NCELL]) << QUO_W);
    end
  end

  assign st_ready = !st_v || dv_ready[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      st_v <= 1'b0;
    end else if (st_ready) begin
      st_v <= sq_valid[NCELL];
    end
    if (st_ready && sq_valid[NCELL]) begin
      st_c   <= st_c_next;
      st_len <= sq_root[NCELL];
      st_n   <= st_n_next;
      st_ovf <= st_ovf_next;
    end
  end

  assign dv_valid[0] = st_v;
  assign dv_c[0]     = st_c;
  assign dv_len[0]   = st_len;
  assign dv_n[0]     = st_n;
  assign dv_q[0]     = '0;
  assign dv_ovf[0]   = st_ovf;
  assign dv_ready[QUO_W] = o_ready;

  for (genvar g = 0; g < QUO_W; g++) begin : g_div
    qau_div_cell #(.NW(NW), .K(QUO_W - 1 - g)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (dv_valid[g]),
      .up_ready  (dv_ready[g]),
      .c_in      (dv_c[g]),
      .len_in    (dv_len[g]),
      .n_in      (dv_n[g]),
      .q_in      (dv_q[g]),
      .ovf_in    (dv_ovf[g]),
      .out_valid (dv_valid[g+1]),
      .dn_ready  (dv_ready[g+1]),
      .c_out     (dv_c[g+1]),
      .len_out   (dv_len[g+1]),
      .n_out     (dv_n[g+1]),
      .q_out     (dv_q[g+1]),
      .ovf_out   (dv_ovf[g+1])
    );
  end

  always_comb begin
    carry_t            c;
    logic [QUO_W-1:0]  q;
    logic [3:0][31:0]  nr;
    logic [3:0]        ns;
    c = dv_c[QUO_W];
    for (int i = 0; i < 4; i++) begin
      q = dv_q[QUO_W][i];
      if (c.neg[i]) begin
        ns[i] = dv_ovf[QUO_W][i] || (q > QUO_W'(33'h080000000));
        nr[i] = ns[i] ? 32'h80000000 : (32'd0 - q[31:0]);
      end else begin
        ns[i] = dv_ovf[QUO_W][i] || (q > QUO_W'(33'h07fffffff));
        nr[i] = ns[i] ? 32'h7fffffff : q[31:0];
      end
    end
    o_r_next   = '0;
    o_sat_next = 1'b0;
    o_deg_next = 1'b0;
    case (c.cmd) inside
      CMD_MUL, CMD_CONJ: begin
        o_r_next   = c.r;
        o_sat_next = c.sat;
      end
      CMD_NORM: begin
        if (c.degen) begin
          o_deg_next = 1'b1;
        end else begin
          o_r_next   = nr;
          o_sat_next = |ns;
        end
      end
      default: begin
        o_r_next = '0;
      end
    endcase
  end

  assign o_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (o_ready) begin
      out_valid <= dv_valid[QUO_W];
    end
    if (o_ready && dv_valid[QUO_W]) begin
      o_r        <= o_r_next;
      saturated  <= o_sat_next;
      degenerate <= o_deg_next;
    end
  end

  assign r_w = o_r[0];
  assign r_x = o_r[1];
  assign r_y = o_r[2];
  assign r_z = o_r[3];

endmodule
`default_nettype wire
